// ----- rtl/hstore_to_json_transcoder_core_macros.svh -----
// Assertion macros shared by the transcoder RTL.
// Users must have clk and arst_n in scope; no other dependencies.
`ifndef HSTORE_TO_JSON_TRANSCODER_CORE_MACROS_SVH
`define HSTORE_TO_JSON_TRANSCODER_CORE_MACROS_SVH

// Property checked on every clock edge outside reset
`define HTJ_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Condition in one cycle implies a condition in the next cycle
`define HTJ_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ----- rtl/htj_pkg.sv -----
// Shared types and constants for the hstore to JSON transcoder.
// No dependencies; imported by htj_parse, htj_obuf and the top level.
`timescale 1ns / 1ps

package htj_pkg;

	// Result list produced for one input request
	localparam int LIST_DEPTH       = 16;
	localparam int LIST_IW          = $clog2(LIST_DEPTH);
	localparam int LIST_CW          = LIST_IW + 1;
	// Longest output run any single input byte can cause
	localparam int MAX_ITEM_RESULTS = 13;

	typedef struct packed {
		logic [LIST_DEPTH-1:0][7:0] data;  // output bytes, first in slot 0
		logic [LIST_CW-1:0]         cnt;   // number of valid slots
		logic                       eor;   // final byte ends the record
		logic                       err;   // final byte is the error marker
	} rlist_t;

endpackage

// ----- rtl/htj_parse.sv -----
// Parser state and single-pass step logic: one input byte to a list of JSON bytes.
// Depends on htj_pkg.
`timescale 1ns / 1ps

module htj_parse (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,          // commit the step for the current request
	input  logic [7:0]      in_byte,
	input  logic            has_byte,
	input  logic            end_of_string,
	output htj_pkg::rlist_t res
);
	import htj_pkg::*;

	typedef enum logic [3:0] {
		M_KEY_WAIT,
		M_KEY_Q,
		M_KEY_Q_ESC,
		M_KEY_U,
		M_KEY_U_ESC,
		M_ARROW_WAIT,
		M_ARROW_GT,
		M_VAL_WAIT,
		M_VAL_Q,
		M_VAL_Q_ESC,
		M_VAL_U,
		M_VAL_U_ESC,
		M_AFTER
	} mode_t;

	typedef struct packed {
		logic [3:0][7:0] held;
		logic [2:0]      hcnt;  // 0..4 bytes held, STREAMING once emitting
	} hold_t;

	localparam logic [2:0] STREAMING = 3'd7;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_EQ     = 8'h3d;
	localparam logic [7:0] CH_GT     = 8'h3e;
	localparam logic [7:0] CH_COMMA  = 8'h2c;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_COLON  = 8'h3a;
	localparam logic [7:0] CH_LBRACE = 8'h7b;
	localparam logic [7:0] CH_RBRACE = 8'h7d;
	localparam logic [7:0] CH_N      = 8'h6e;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_L      = 8'h6c;

	// ---------------------------------------------------------------
	// Helpers
	// ---------------------------------------------------------------
	function automatic rlist_t app(rlist_t l, logic [7:0] b);
		rlist_t r;
		r = l;
		if (l.cnt < LIST_CW'(LIST_DEPTH)) begin
			r.data[l.cnt[LIST_IW-1:0]] = b;
			r.cnt = l.cnt + LIST_CW'(1);
		end
		return r;
	endfunction

	function automatic logic [7:0] hex_digit(logic [3:0] d);
		return (d < 4'd10) ? (8'h30 + {4'h0, d}) : (8'h57 + {4'h0, d});
	endfunction

	function automatic logic is_ws(logic [7:0] c);
		return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0d);
	endfunction

	function automatic logic [7:0] to_lower(logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5a) ? (c + 8'd32) : c;
	endfunction

	// JSON string escaping of one byte
	function automatic rlist_t app_esc(rlist_t l, logic [7:0] c);
		rlist_t r;
		r = l;
		case (c)
			CH_QUOTE:  begin r = app(r, CH_BSLASH); r = app(r, CH_QUOTE);  end
			CH_BSLASH: begin r = app(r, CH_BSLASH); r = app(r, CH_BSLASH); end
			8'h08:     begin r = app(r, CH_BSLASH); r = app(r, 8'h62); end
			8'h0c:     begin r = app(r, CH_BSLASH); r = app(r, 8'h66); end
			8'h0a:     begin r = app(r, CH_BSLASH); r = app(r, CH_N);  end
			8'h0d:     begin r = app(r, CH_BSLASH); r = app(r, 8'h72); end
			8'h09:     begin r = app(r, CH_BSLASH); r = app(r, 8'h74); end
			default: begin
				if (c < 8'h20) begin
					r = app(r, CH_BSLASH);
					r = app(r, CH_U);
					r = app(r, 8'h30);
					r = app(r, 8'h30);
					r = app(r, hex_digit(c[7:4]));
					r = app(r, hex_digit(c[3:0]));
				end else begin
					r = app(r, c);
				end
			end
		endcase
		return r;
	endfunction

	// True if c extends the held text as a prefix of NULL, any case
	function automatic logic null_hold(hold_t h, logic [7:0] c);
		logic [7:0] want;
		case (h.hcnt[1:0])
			2'd0:    want = CH_N;
			2'd1:    want = CH_U;
			default: want = CH_L;
		endcase
		return (h.hcnt < 3'd4) && (to_lower(c) == want);
	endfunction

	// Output side of adding one unquoted value byte
	function automatic rlist_t vadd_list(rlist_t l, hold_t h, logic [7:0] c);
		rlist_t r;
		r = l;
		if (h.hcnt == STREAMING) begin
			r = app_esc(r, c);
		end else if (!null_hold(h, c)) begin
			// flush quote and held prefix, then stream on
			r = app(r, CH_QUOTE);
			for (int i = 0; i < 4; i++) begin
				if (3'(i) < h.hcnt) r = app(r, h.held[i]);
			end
			r = app_esc(r, c);
		end
		return r;
	endfunction

	// Hold state after adding one unquoted value byte
	function automatic hold_t vadd_state(hold_t h, logic [7:0] c);
		hold_t r;
		r = h;
		if (h.hcnt != STREAMING) begin
			if (null_hold(h, c)) begin
				r.held[h.hcnt[1:0]] = c;
				r.hcnt = h.hcnt + 3'd1;
			end else begin
				r.hcnt = STREAMING;
			end
		end
		return r;
	endfunction

	// Close an unquoted value: JSON null, or the quoted text
	function automatic rlist_t vclose_list(rlist_t l, hold_t h);
		rlist_t r;
		r = l;
		if (h.hcnt == STREAMING) begin
			r = app(r, CH_QUOTE);
		end else if (h.hcnt == 3'd4) begin
			r = app(r, CH_N); r = app(r, CH_U); r = app(r, CH_L); r = app(r, CH_L);
		end else begin
			r = app(r, CH_QUOTE);
			for (int i = 0; i < 4; i++) begin
				if (3'(i) < h.hcnt) r = app(r, h.held[i]);
			end
			r = app(r, CH_QUOTE);
		end
		return r;
	endfunction

	// ---------------------------------------------------------------
	// State
	// ---------------------------------------------------------------
	mode_t           mode_q, n_mode;
	logic [3:0][7:0] held_q;
	logic [2:0]      hcnt_q;
	logic            pair_q, n_pair;
	logic            rec_open_q, n_open;
	logic            sink_q, n_sink;
	hold_t           cur_hold, n_hold;
	rlist_t          l;
	logic            ok;
	logic            ws;
	hold_t           h0;

	assign cur_hold = '{held: held_q, hcnt: hcnt_q};
	assign ws       = is_ws(in_byte);

	// ---------------------------------------------------------------
	// Step logic for the request in the input register
	// ---------------------------------------------------------------
	always_comb begin
		l      = '0;
		ok     = 1'b1;
		n_mode = mode_q;
		n_hold = cur_hold;
		n_pair = pair_q;
		n_open = rec_open_q;
		n_sink = sink_q;
		h0     = cur_hold;
		h0.hcnt = 3'd0;

		if (has_byte || end_of_string) begin
			if (sink_q) begin
				// dropping bytes after an error until the string ends
				if (end_of_string) begin
					n_mode = M_KEY_WAIT; n_hold.hcnt = 3'd0;
					n_pair = 1'b0; n_open = 1'b0; n_sink = 1'b0;
				end
			end else begin
				if (!rec_open_q) begin
					l = app(l, CH_LBRACE);
					n_open = 1'b1;
				end

				// byte handling
				if (has_byte) begin
					case (mode_q)
						M_KEY_WAIT: begin
							if (in_byte == CH_EQ) begin
								ok = 1'b0;
							end else if (!ws) begin
								if (pair_q) begin
									l = app(l, CH_COMMA);
									l = app(l, CH_SPACE);
								end
								n_pair = 1'b1;
								l = app(l, CH_QUOTE);
								if (in_byte == CH_QUOTE) n_mode = M_KEY_Q;
								else if (in_byte == CH_BSLASH) n_mode = M_KEY_U_ESC;
								else begin
									l = app_esc(l, in_byte);
									n_mode = M_KEY_U;
								end
							end
						end
						M_KEY_Q: begin
							if (in_byte == CH_QUOTE) begin
								l = app(l, CH_QUOTE);
								n_mode = M_ARROW_WAIT;
							end else if (in_byte == CH_BSLASH) n_mode = M_KEY_Q_ESC;
							else l = app_esc(l, in_byte);
						end
						M_KEY_Q_ESC: begin
							l = app_esc(l, in_byte);
							n_mode = M_KEY_Q;
						end
						M_KEY_U: begin
							if (ws) begin
								l = app(l, CH_QUOTE);
								n_mode = M_ARROW_WAIT;
							end else if (in_byte == CH_EQ) begin
								l = app(l, CH_QUOTE);
								n_mode = M_ARROW_GT;
							end else if (in_byte == CH_BSLASH) n_mode = M_KEY_U_ESC;
							else l = app_esc(l, in_byte);
						end
						M_KEY_U_ESC: begin
							l = app_esc(l, in_byte);
							n_mode = M_KEY_U;
						end
						M_ARROW_WAIT: begin
							if (!ws) begin
								if (in_byte != CH_EQ) ok = 1'b0;
								else n_mode = M_ARROW_GT;
							end
						end
						M_ARROW_GT: begin
							if (in_byte != CH_GT) ok = 1'b0;
							else begin
								l = app(l, CH_COLON);
								l = app(l, CH_SPACE);
								n_mode = M_VAL_WAIT;
							end
						end
						M_VAL_WAIT: begin
							if (!ws) begin
								n_hold.hcnt = 3'd0;
								if (in_byte == CH_QUOTE) begin
									l = app(l, CH_QUOTE);
									n_mode = M_VAL_Q;
								end else if (in_byte == CH_COMMA) begin
									l = vclose_list(l, h0);
									n_mode = M_KEY_WAIT;
								end else if (in_byte == CH_BSLASH) begin
									n_mode = M_VAL_U_ESC;
								end else begin
									l = vadd_list(l, h0, in_byte);
									n_hold = vadd_state(h0, in_byte);
									n_mode = M_VAL_U;
								end
							end
						end
						M_VAL_Q: begin
							if (in_byte == CH_QUOTE) begin
								l = app(l, CH_QUOTE);
								n_mode = M_AFTER;
							end else if (in_byte == CH_BSLASH) n_mode = M_VAL_Q_ESC;
							else l = app_esc(l, in_byte);
						end
						M_VAL_Q_ESC: begin
							l = app_esc(l, in_byte);
							n_mode = M_VAL_Q;
						end
						M_VAL_U: begin
							if (ws) begin
								l = vclose_list(l, cur_hold);
								n_hold.hcnt = 3'd0;
								n_mode = M_AFTER;
							end else if (in_byte == CH_COMMA) begin
								l = vclose_list(l, cur_hold);
								n_hold.hcnt = 3'd0;
								n_mode = M_KEY_WAIT;
							end else if (in_byte == CH_BSLASH) n_mode = M_VAL_U_ESC;
							else begin
								l = vadd_list(l, cur_hold, in_byte);
								n_hold = vadd_state(cur_hold, in_byte);
							end
						end
						M_VAL_U_ESC: begin
							l = vadd_list(l, cur_hold, in_byte);
							n_hold = vadd_state(cur_hold, in_byte);
							n_mode = M_VAL_U;
						end
						M_AFTER: begin
							if (!ws) begin
								if (in_byte != CH_COMMA) ok = 1'b0;
								else n_mode = M_KEY_WAIT;
							end
						end
						default: ok = 1'b0;
					endcase
				end

				// end of string: finish the open value and close the object
				if (ok && end_of_string) begin
					case (n_mode)
						M_KEY_WAIT, M_AFTER: ;
						M_VAL_WAIT: begin
							l = app(l, CH_N); l = app(l, CH_U);
							l = app(l, CH_L); l = app(l, CH_L);
						end
						M_VAL_U: l = vclose_list(l, n_hold);
						default: ok = 1'b0;
					endcase
					if (ok) begin
						l = app(l, CH_RBRACE);
						l.eor = 1'b1;
					end
				end

				// error marker, then drop until the end of the string
				if (!ok) begin
					l = app(l, 8'h00);
					l.eor = 1'b1;
					l.err = 1'b1;
					if (!end_of_string) n_sink = 1'b1;
				end
				if (end_of_string) begin
					n_mode = M_KEY_WAIT; n_hold.hcnt = 3'd0;
					n_pair = 1'b0; n_open = 1'b0; n_sink = 1'b0;
				end
			end
		end
	end

	assign res = l;

	// ---------------------------------------------------------------
	// Parser state registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= M_KEY_WAIT;
			hcnt_q     <= 3'd0;
			pair_q     <= 1'b0;
			rec_open_q <= 1'b0;
			sink_q     <= 1'b0;
		end else if (take) begin
			mode_q     <= n_mode;
			hcnt_q     <= n_hold.hcnt;
			pair_q     <= n_pair;
			rec_open_q <= n_open;
			sink_q     <= n_sink;
		end
	end

	// held value bytes are only read below the held count
	always_ff @(posedge clk) begin
		if (take) held_q <= n_hold.held;
	end

endmodule

// ----- rtl/htj_obuf.sv -----
// Result register: one request's JSON byte list, sent a byte per cycle while tready.
// Depends on htj_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "hstore_to_json_transcoder_core_macros.svh"

module htj_obuf (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,           // take a new, non-empty result list
	input  htj_pkg::rlist_t res,
	output logic            free,           // a list may be loaded this cycle
	output logic            m_axis_tvalid,
	input  logic            m_axis_tready,
	output logic [15:0]     m_axis_tdata,   // [7:0] out_byte, [8] last, rest zero
	output logic            m_axis_tlast,   // end_of_record
	output logic            m_axis_tuser    // syntax_error
);
	import htj_pkg::*;

	logic [LIST_DEPTH-1:0][7:0] data_q;
	logic [LIST_CW-1:0]         cnt_q;
	logic                       eor_q;
	logic                       err_q;
	logic                       valid_q;
	logic [LIST_IW-1:0]         idx_q;
	logic                       is_last;

	assign is_last = (({1'b0, idx_q} + LIST_CW'(1)) == cnt_q);
	assign free    = !valid_q || (m_axis_tready && is_last);

	// output request
	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {7'd0, is_last, data_q[idx_q]};
	assign m_axis_tlast  = is_last && eor_q;
	assign m_axis_tuser  = is_last && err_q;

	// control: valid and read index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (valid_q && m_axis_tready) begin
			if (is_last) valid_q <= 1'b0;
			else idx_q <= idx_q + LIST_IW'(1);
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res.data;
			cnt_q  <= res.cnt;
			eor_q  <= res.eor;
			err_q  <= res.err;
		end
	end

	`HTJ_ASSERT(a_load_when_free, load |-> free, "result list loaded over a pending one")
	`HTJ_ASSERT(a_idx_in_range, valid_q |-> (cnt_q != '0 && {1'b0, idx_q} < cnt_q), "read index outside list")
	`HTJ_ASSERT_NEXT(a_idx_step, valid_q && m_axis_tready && !is_last, valid_q && idx_q == $past(idx_q) + LIST_IW'(1), "read index did not advance")

endmodule

// ----- rtl/hstore_to_json_transcoder_core.sv -----
// hstore text to JSON object transcoder, byte-stream in, byte-stream out.
// Instantiates htj_parse and htj_obuf; depends on htj_pkg and the macro header.
//
// Takes hstore text one byte per request and emits the equivalent JSON object text.
// An input request is registered, converted in one pass to a list of up to 13 JSON
// bytes, and that list is loaded into the result register, which sends one byte per
// cycle while m_axis_tready is high. A request that yields zero or one byte moves on
// every cycle while the output is ready, so plain text runs at one byte per cycle; a
// request that yields more bytes holds the result register until all are sent
// (escapes, separators and flushed NULL prefixes). Malformed text gives one error
// request (syntax_error and tlast set, data zero); the consumer drops that record.
`timescale 1ns / 1ps
`include "hstore_to_json_transcoder_core_macros.svh"

module hstore_to_json_transcoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	input  logic        s_axis_tlast,   // end_of_string
	input  logic        s_axis_tuser,   // has_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [8] last, rest zero
	output logic        m_axis_tlast,   // end_of_record
	output logic        m_axis_tuser    // syntax_error
);
	import htj_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       hb_s1;
	logic       eos_s1;
	logic       adv;
	logic       ob_free;
	rlist_t     plist;

	// the registered request moves on when its results have a place to go
	assign adv           = valid_s1 && (plist.cnt == '0 || ob_free);
	assign s_axis_tready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			hb_s1   <= s_axis_tuser;
			eos_s1  <= s_axis_tlast;
		end
	end

	htj_parse u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (adv),
		.in_byte       (byte_s1),
		.has_byte      (hb_s1),
		.end_of_string (eos_s1),
		.res           (plist)
	);

	htj_obuf u_obuf (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (adv && plist.cnt != '0),
		.res           (plist),
		.free          (ob_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	`HTJ_ASSERT(a_list_bound, valid_s1 |-> plist.cnt <= LIST_CW'(MAX_ITEM_RESULTS), "result list longer than expected")
	`HTJ_ASSERT(a_err_ends_record, (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast, "error byte not at record end")
	`HTJ_ASSERT_NEXT(a_s1_hold, valid_s1 && !adv, valid_s1 && byte_s1 == $past(byte_s1) && eos_s1 == $past(eos_s1), "stalled input request changed")

endmodule

// ----- tb/tb_hstore_to_json_transcoder_core.sv -----
// Self-checking testbench for hstore_to_json_transcoder_core.
// Streams hstore text in, predicts the JSON bytes and checks them as they arrive.
// Depends only on the transcoder RTL.
`timescale 1ns / 1ps

module tb_hstore_to_json_transcoder_core;

	localparam int RANDOM_ITEMS   = 230;
	localparam int MAX_ITEM_BYTES = 28;
	localparam int MAX_REPORTS    = 10;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int SETTLE_CYCLES  = 20;
	localparam int DRAIN_QUIET    = 4;

	// Byte values the parser and the JSON writer care about
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_EQ     = 8'h3d;
	localparam logic [7:0] CH_GT     = 8'h3e;
	localparam logic [7:0] CH_COMMA  = 8'h2c;
	localparam logic [7:0] CH_COLON  = 8'h3a;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LBRACE = 8'h7b;
	localparam logic [7:0] CH_RBRACE = 8'h7d;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_FF     = 8'h0c;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [31:0] NULL_WORD = "null";
	// null_len value once an unquoted value is known not to be NULL
	localparam logic [2:0] VALUE_LIVE = 3'd7;

	typedef enum logic [3:0] {
		PS_KEY_WAIT, PS_KEY_Q, PS_KEY_Q_ESC, PS_KEY_U, PS_KEY_U_ESC,
		PS_ARROW_WAIT, PS_ARROW_GT, PS_VAL_WAIT, PS_VAL_Q, PS_VAL_Q_ESC,
		PS_VAL_U, PS_VAL_U_ESC, PS_AFTER_VAL
	} hs_state_t;

	typedef struct packed {
		logic [7:0] data;
		logic       has_byte;
		logic       eos;
		logic       wait_idle;   // hold until all JSON bytes are out
		logic [3:0] gap;         // idle cycles after this request
	} hstore_item_t;

	typedef struct packed {
		logic [7:0] data;
		logic       eor;
		logic       err;
		logic       last;
	} json_byte_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] in_byte
	logic        s_axis_tlast = 1'b0;    // end_of_string
	logic        s_axis_tuser = 1'b0;    // has_byte
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;           // [7:0] out_byte, [8] last
	logic        m_axis_tlast;           // end_of_record
	logic        m_axis_tuser;           // syntax_error

	hstore_to_json_transcoder_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	// Predictor state
	hs_state_t  hs_state;
	logic [7:0] null_buf [4];
	logic [2:0] null_len;
	logic       need_comma;
	logic       brace_sent;
	logic       skip_to_end;

	json_byte_t   step_out[$];
	json_byte_t   json_expected[$];
	hstore_item_t hstore_pending[$];
	logic [7:0]   hs_text[$];

	int mismatches = 0;
	int stim_count = 0;
	int rx_count = 0;
	int idle_cycles = 0;
	int quiet_cycles = 0;
	int gap_left = 0;
	int stall_left = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Append one byte to the text being built
	function automatic void text_add(logic [7:0] c);
		hs_text.insert(hs_text.size(), c);
	endfunction

	// ---------------------------------------------------------------- predictor

	function automatic void json_put(logic [7:0] b, logic eor = 1'b0, logic err = 1'b0);
		json_byte_t r;
		if (step_out.size() < MAX_ITEM_BYTES) begin
			r.data = b;
			r.eor = eor;
			r.err = err;
			r.last = 1'b0;
			step_out.insert(step_out.size(), r);
		end
	endfunction

	function automatic logic [7:0] hex_digit(logic [3:0] n);
		return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h57 + {4'h0, n});
	endfunction

	function automatic logic [7:0] null_letter(int i);
		return NULL_WORD[31 - 8 * i -: 8];
	endfunction

	function automatic logic is_ws(logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic [7:0] to_lower(logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	// JSON string escaping of one byte
	function automatic void json_put_char(logic [7:0] c);
		case (c)
			CH_QUOTE: begin
				json_put(CH_BSLASH);
				json_put(CH_QUOTE);
			end
			CH_BSLASH: begin
				json_put(CH_BSLASH);
				json_put(CH_BSLASH);
			end
			CH_BS: begin
				json_put(CH_BSLASH);
				json_put("b");
			end
			CH_FF: begin
				json_put(CH_BSLASH);
				json_put("f");
			end
			CH_LF: begin
				json_put(CH_BSLASH);
				json_put("n");
			end
			CH_CR: begin
				json_put(CH_BSLASH);
				json_put("r");
			end
			CH_TAB: begin
				json_put(CH_BSLASH);
				json_put("t");
			end
			default: begin
				if (c < CH_SPACE) begin
					json_put(CH_BSLASH);
					json_put("u");
					json_put("0");
					json_put("0");
					json_put(hex_digit(c[7:4]));
					json_put(hex_digit(c[3:0]));
				end else begin
					json_put(c);
				end
			end
		endcase
	endfunction

	function automatic void clear_null_buf();
		foreach (null_buf[i])
			null_buf[i] = 8'h00;
		null_len = 3'd0;
	endfunction

	function automatic void clear_record();
		hs_state = PS_KEY_WAIT;
		clear_null_buf();
		need_comma = 1'b0;
		brace_sent = 1'b0;
		skip_to_end = 1'b0;
	endfunction

	// Unquoted value byte: held back while it may still spell NULL
	function automatic void value_byte(logic [7:0] c);
		if (null_len == VALUE_LIVE) begin
			json_put_char(c);
		end else if (null_len < 3'd4 && to_lower(c) == null_letter(int'(null_len))) begin
			null_buf[null_len[1:0]] = c;
			null_len = null_len + 3'd1;
		end else begin
			json_put(CH_QUOTE);
			for (int i = 0; i < int'(null_len); i++)
				json_put_char(null_buf[i]);
			json_put_char(c);
			null_len = VALUE_LIVE;
		end
	endfunction

	function automatic void value_end();
		if (null_len == VALUE_LIVE) begin
			json_put(CH_QUOTE);
		end else if (null_len == 3'd4) begin
			for (int i = 0; i < 4; i++)
				json_put(null_letter(i));
		end else begin
			json_put(CH_QUOTE);
			for (int i = 0; i < int'(null_len); i++)
				json_put_char(null_buf[i]);
			json_put(CH_QUOTE);
		end
		clear_null_buf();
	endfunction

	function automatic void key_open();
		if (need_comma) begin
			json_put(CH_COMMA);
			json_put(CH_SPACE);
		end
		need_comma = 1'b1;
		json_put(CH_QUOTE);
	endfunction

	// One text byte; returns 0 on malformed text
	function automatic logic parse_byte(logic [7:0] c);
		case (hs_state)
			PS_KEY_WAIT: begin
				if (is_ws(c))
					return 1'b1;
				if (c == CH_EQ)
					return 1'b0;
				key_open();
				if (c == CH_QUOTE)
					hs_state = PS_KEY_Q;
				else if (c == CH_BSLASH)
					hs_state = PS_KEY_U_ESC;
				else begin
					json_put_char(c);
					hs_state = PS_KEY_U;
				end
			end
			PS_KEY_Q: begin
				if (c == CH_QUOTE) begin
					json_put(CH_QUOTE);
					hs_state = PS_ARROW_WAIT;
				end else if (c == CH_BSLASH) begin
					hs_state = PS_KEY_Q_ESC;
				end else begin
					json_put_char(c);
				end
			end
			PS_KEY_Q_ESC: begin
				json_put_char(c);
				hs_state = PS_KEY_Q;
			end
			PS_KEY_U: begin
				if (is_ws(c)) begin
					json_put(CH_QUOTE);
					hs_state = PS_ARROW_WAIT;
				end else if (c == CH_EQ) begin
					json_put(CH_QUOTE);
					hs_state = PS_ARROW_GT;
				end else if (c == CH_BSLASH) begin
					hs_state = PS_KEY_U_ESC;
				end else begin
					json_put_char(c);
				end
			end
			PS_KEY_U_ESC: begin
				json_put_char(c);
				hs_state = PS_KEY_U;
			end
			PS_ARROW_WAIT: begin
				if (is_ws(c))
					return 1'b1;
				if (c != CH_EQ)
					return 1'b0;
				hs_state = PS_ARROW_GT;
			end
			PS_ARROW_GT: begin
				if (c != CH_GT)
					return 1'b0;
				json_put(CH_COLON);
				json_put(CH_SPACE);
				hs_state = PS_VAL_WAIT;
			end
			PS_VAL_WAIT: begin
				if (is_ws(c))
					return 1'b1;
				null_len = 3'd0;
				if (c == CH_QUOTE) begin
					json_put(CH_QUOTE);
					hs_state = PS_VAL_Q;
				end else if (c == CH_COMMA) begin
					value_end();
					hs_state = PS_KEY_WAIT;
				end else if (c == CH_BSLASH) begin
					hs_state = PS_VAL_U_ESC;
				end else begin
					value_byte(c);
					hs_state = PS_VAL_U;
				end
			end
			PS_VAL_Q: begin
				if (c == CH_QUOTE) begin
					json_put(CH_QUOTE);
					hs_state = PS_AFTER_VAL;
				end else if (c == CH_BSLASH) begin
					hs_state = PS_VAL_Q_ESC;
				end else begin
					json_put_char(c);
				end
			end
			PS_VAL_Q_ESC: begin
				json_put_char(c);
				hs_state = PS_VAL_Q;
			end
			PS_VAL_U: begin
				if (is_ws(c)) begin
					value_end();
					hs_state = PS_AFTER_VAL;
				end else if (c == CH_COMMA) begin
					value_end();
					hs_state = PS_KEY_WAIT;
				end else if (c == CH_BSLASH) begin
					hs_state = PS_VAL_U_ESC;
				end else begin
					value_byte(c);
				end
			end
			PS_VAL_U_ESC: begin
				value_byte(c);
				hs_state = PS_VAL_U;
			end
			PS_AFTER_VAL: begin
				if (is_ws(c))
					return 1'b1;
				if (c != CH_COMMA)
					return 1'b0;
				hs_state = PS_KEY_WAIT;
			end
			default: return 1'b0;
		endcase
		return 1'b1;
	endfunction

	// End of text: closes any open value and the object
	function automatic logic parse_end();
		case (hs_state)
			PS_KEY_WAIT, PS_AFTER_VAL: ;
			PS_VAL_WAIT: begin
				for (int i = 0; i < 4; i++)
					json_put(null_letter(i));
			end
			PS_VAL_U: value_end();
			default: return 1'b0;
		endcase
		json_put(CH_RBRACE, 1'b1, 1'b0);
		return 1'b1;
	endfunction

	// Expected JSON bytes for one accepted request
	function automatic void predict_json(logic [7:0] c, logic hb, logic eos);
		logic ok;
		json_byte_t r;
		step_out.delete();
		if (!hb && !eos)
			return;
		if (skip_to_end) begin
			if (eos)
				clear_record();
			return;
		end
		if (!brace_sent) begin
			json_put(CH_LBRACE);
			brace_sent = 1'b1;
		end
		ok = 1'b1;
		if (hb)
			ok = parse_byte(c);
		if (ok && eos)
			ok = parse_end();
		if (!ok) begin
			json_put(8'h00, 1'b1, 1'b1);
			if (eos)
				clear_record();
			else
				skip_to_end = 1'b1;
		end else if (eos) begin
			clear_record();
		end
		// mark the final byte of this request
		if (step_out.size() > 0) begin
			r = step_out[step_out.size() - 1];
			r.last = 1'b1;
			step_out[step_out.size() - 1] = r;
		end
		foreach (step_out[i])
			json_expected.insert(json_expected.size(), step_out[i]);
	endfunction

	function automatic void note_mismatch(string what);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t mismatch: %s", $time, what);
	endfunction

	// ---------------------------------------------------------------- stimulus

	function automatic void push_item(logic [7:0] d, logic hb, logic eos, logic hold = 1'b0);
		hstore_item_t it;
		it.data = d;
		it.has_byte = hb;
		it.eos = eos;
		it.wait_idle = hold;
		// every third stretch of requests runs back to back
		if (((stim_count / 37) % 3) == 2 || $urandom_range(0, 2) == 0)
			it.gap = 4'd0;
		else
			it.gap = 4'($urandom_range(0, 11));
		hstore_pending.insert(hstore_pending.size(), it);
		if (hb || eos)
			stim_count++;
	endfunction

	// Queue the text as one string; end on the last byte or on a bare end request
	function automatic void send_text(logic hold, logic bare_end);
		int n;
		n = hs_text.size();
		if (n == 0)
			bare_end = 1'b1;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 24) == 0)
				push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			push_item(hs_text[i], 1'b1, !bare_end && i == n - 1, hold && i == 0);
		end
		if (bare_end)
			push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, hold && n == 0);
	endfunction

	function automatic void load_text(string s);
		hs_text.delete();
		for (int i = 0; i < s.len(); i++)
			text_add(s[i]);
	endfunction

	function automatic logic [7:0] text_byte();
		case ($urandom_range(0, 9))
			0, 1, 2: return 8'h61 + 8'($urandom_range(0, 25));
			3:       return 8'h41 + 8'($urandom_range(0, 25));
			4:       return 8'h21 + 8'($urandom_range(0, 94));
			5:       return 8'($urandom_range(0, 31));
			6:       return 8'($urandom_range(128, 255));
			7:       return $urandom_range(0, 1) ? CH_QUOTE : CH_BSLASH;
			default: return 8'h30 + 8'($urandom_range(0, 9));
		endcase
	endfunction

	function automatic void add_ws();
		int sel;
		repeat ($urandom_range(0, 2)) begin
			sel = $urandom_range(0, 5);
			text_add(sel == 5 ? CH_SPACE : CH_TAB + 8'(sel));
		end
	endfunction

	function automatic void add_quoted(int len);
		logic [7:0] c;
		text_add(CH_QUOTE);
		for (int i = 0; i < len; i++) begin
			c = text_byte();
			if (c == CH_QUOTE || c == CH_BSLASH || $urandom_range(0, 9) == 0)
				text_add(CH_BSLASH);
			text_add(c);
		end
		text_add(CH_QUOTE);
	endfunction

	// Unquoted key or value; bytes that would end it are escaped
	function automatic void add_bare(int len, logic is_key);
		logic [7:0] c;
		logic stop;
		for (int i = 0; i < len; i++) begin
			c = text_byte();
			stop = is_ws(c) || c == CH_BSLASH || (i == 0 && c == CH_QUOTE) ||
				(is_key ? c == CH_EQ : c == CH_COMMA);
			if (stop || $urandom_range(0, 9) == 0)
				text_add(CH_BSLASH);
			text_add(c);
		end
	endfunction

	// NULL in mixed case, a prefix of it, or NULL with a tail
	function automatic void add_null_like();
		logic [7:0] c;
		int n;
		n = $urandom_range(1, 4);
		for (int i = 0; i < n; i++) begin
			c = null_letter(i);
			if ($urandom_range(0, 1))
				c = c - 8'h20;
			if ($urandom_range(0, 7) == 0)
				text_add(CH_BSLASH);
			text_add(c);
		end
		if ($urandom_range(0, 2) == 0)
			add_bare($urandom_range(1, 2), 1'b0);
	endfunction

	function automatic void build_record();
		int npairs;
		logic comma_done;
		hs_text.delete();
		npairs = $urandom_range(0, 3);
		comma_done = 1'b1;
		add_ws();
		for (int p = 0; p < npairs; p++) begin
			if (!comma_done) begin
				add_ws();
				text_add(CH_COMMA);
			end
			add_ws();
			comma_done = 1'b0;
			if ($urandom_range(0, 1))
				add_quoted($urandom_range(0, 4));
			else
				add_bare($urandom_range(1, 4), 1'b1);
			add_ws();
			text_add(CH_EQ);
			text_add(CH_GT);
			add_ws();
			// missing value at the very end reads as null
			if (p == npairs - 1 && $urandom_range(0, 5) == 0)
				return;
			case ($urandom_range(0, 4))
				0: add_quoted($urandom_range(0, 5));
				1: add_bare($urandom_range(1, 5), 1'b0);
				2, 3: add_null_like();
				default: begin
					text_add(CH_COMMA);
					comma_done = 1'b1;
				end
			endcase
		end
		add_ws();
		if (!comma_done && npairs > 0 && $urandom_range(0, 3) == 0) begin
			text_add(CH_COMMA);
			add_ws();
		end
	endfunction

	function automatic void build_broken();
		int n;
		case ($urandom_range(0, 2))
			0: begin
				build_record();
				hs_text.insert($urandom_range(0, hs_text.size()), 8'($urandom_range(0, 255)));
			end
			1: begin
				build_record();
				n = $urandom_range(0, hs_text.size());
				while (hs_text.size() > n)
					void'(hs_text.pop_back());
			end
			default: begin
				hs_text.delete();
				repeat ($urandom_range(1, 8))
					text_add(8'($urandom_range(0, 255)));
			end
		endcase
	endfunction

	// ---------------------------------------------------------------- driver

	always @(posedge clk) begin
		hstore_item_t nxt;
		if (arst_n) begin
			if (json_expected.size() == 0 && !s_axis_tvalid)
				quiet_cycles++;
			else
				quiet_cycles = 0;
			// a request still waiting for tready stays on the bus
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (hstore_pending.size() != 0 &&
					(!hstore_pending[0].wait_idle || quiet_cycles >= DRAIN_QUIET)) begin
					nxt = hstore_pending.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= nxt.data;
					s_axis_tuser <= nxt.has_byte;
					s_axis_tlast <= nxt.eos;
					gap_left = int'(nxt.gap);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	always @(posedge clk) begin
		json_byte_t want;
		logic out_acc;
		logic in_acc;
		if (arst_n) begin
			out_acc = m_axis_tvalid && m_axis_tready;
			in_acc = s_axis_tvalid && s_axis_tready;
			// check first, so a result never matches an expectation added this edge
			if (out_acc) begin
				rx_count++;
				if (json_expected.size() == 0) begin
					note_mismatch($sformatf("unexpected result tdata=%h tlast=%b tuser=%b",
						m_axis_tdata, m_axis_tlast, m_axis_tuser));
				end else begin
					want = json_expected.pop_front();
					if (m_axis_tdata[7:0] !== want.data || m_axis_tdata[8] !== want.last ||
						m_axis_tdata[15:9] !== 7'd0 || m_axis_tlast !== want.eor ||
						m_axis_tuser !== want.err)
						note_mismatch($sformatf({"result %0d: expected byte=%h last=%b eor=%b ",
							"err=%b, got tdata=%h tlast=%b tuser=%b"}, rx_count, want.data,
							want.last, want.eor, want.err, m_axis_tdata, m_axis_tlast,
							m_axis_tuser));
				end
				if (((rx_count / 53) % 3) == 1 || $urandom_range(0, 2) == 0)
					stall_left = 0;
				else
					stall_left = $urandom_range(0, 11);
			end else if (stall_left > 0) begin
				stall_left--;
			end
			m_axis_tready <= (stall_left == 0);
			if (in_acc)
				predict_json(s_axis_tdata, s_axis_tuser, s_axis_tlast);
			idle_cycles = (out_acc || in_acc) ? 0 : idle_cycles + 1;
		end
	end

	// ---------------------------------------------------------------- watchdog

	initial begin
		while (idle_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		int dir_count;
		logic first;
		clear_record();

		// empty text gives an empty object
		hs_text.delete();
		send_text(1'b0, 1'b1);
		// mixed-case NULL value, trailing comma
		load_text("x=>nULl,");
		send_text(1'b0, 1'b0);
		// control bytes and 0xff in a quoted key, empty value, missing value at the end
		hs_text.delete();
		text_add(CH_QUOTE);
		text_add(8'h00);
		text_add(8'hff);
		text_add(CH_BS);
		text_add(CH_QUOTE);
		text_add(CH_EQ);
		text_add(CH_GT);
		text_add(CH_COMMA);
		text_add("z");
		text_add(CH_EQ);
		text_add(CH_GT);
		send_text(1'b0, 1'b0);
		// error, then bytes ignored up to the end request
		push_item(CH_EQ, 1'b1, 1'b0);
		push_item("a", 1'b1, 1'b0);
		push_item(8'hff, 1'b0, 1'b1);
		// error on the request that ends the string
		push_item("q", 1'b1, 1'b1);
		// empty request
		push_item(8'h00, 1'b0, 1'b0);
		dir_count = stim_count;

		// random strings, mostly well formed
		first = 1'b1;
		while (stim_count < dir_count + RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) != 0)
				build_record();
			else
				build_broken();
			send_text(first || $urandom_range(0, 11) == 0, $urandom_range(0, 2) == 0);
			first = 1'b0;
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (hstore_pending.size() != 0 || s_axis_tvalid || json_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- hstore_to_json_transcoder_core.f -----
+incdir+rtl
rtl/htj_pkg.sv
rtl/htj_parse.sv
rtl/htj_obuf.sv
rtl/hstore_to_json_transcoder_core.sv
tb/tb_hstore_to_json_transcoder_core.sv
